[sv/ecu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_pkg: shared types and constants of the easing curve unit
// Field widths, curve codes, Q16 coefficients, the control word that travels
// down the pipeline, and the quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package ecu_pkg;

    localparam int NUM_STAGES = 7;

    localparam int KIND_W = 4;
    localparam int POS_W  = 17;
    localparam int OUT_W  = 18;
    localparam int FRAC_W = 16;

    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int SINE_SCALE_W       = FRAC_W + SINE_IDX_W;

    localparam int X2_W   = 2 * FRAC_W + 1;
    localparam int X3_W   = 3 * FRAC_W + 1;
    localparam int COEF_W = 18;
    localparam int PROD_W = X2_W + COEF_W;

    localparam logic [POS_W-1:0]  ONE_Q16 = 17'h10000;
    localparam logic [COEF_W-1:0] C1_Q16  = 18'd111515;
    localparam logic [COEF_W-1:0] C3_Q16  = 18'd177051;
    localparam logic [COEF_W-1:0] C2_Q16  = 18'd170060;
    localparam logic [COEF_W-1:0] D3_Q16  = 18'd235596;

    localparam logic signed [OUT_W-1:0] SAT_MIN = -18'sd8192;
    localparam logic signed [OUT_W-1:0] SAT_MAX = 18'sd73728;

    localparam logic [KIND_W-1:0] KIND_LINEAR      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SINE_IN     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_SINE_OUT    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SINE_INOUT  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_QUAD_IN     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_QUAD_OUT    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_QUAD_INOUT  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CUBIC_IN    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CUBIC_OUT   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_CUBIC_INOUT = 4'd9;
    localparam logic [KIND_W-1:0] KIND_BACK_IN     = 4'd10;
    localparam logic [KIND_W-1:0] KIND_BACK_OUT    = 4'd11;
    localparam logic [KIND_W-1:0] KIND_BACK_INOUT  = 4'd12;

    localparam logic [2:0] CLS_LINEAR = 3'd0;
    localparam logic [2:0] CLS_SINE   = 3'd1;
    localparam logic [2:0] CLS_QUAD   = 3'd2;
    localparam logic [2:0] CLS_CUBIC  = 3'd3;
    localparam logic [2:0] CLS_BACK   = 3'd4;

    localparam logic [1:0] FORM_IN    = 2'd0;
    localparam logic [1:0] FORM_OUT   = 2'd1;
    localparam logic [1:0] FORM_INOUT = 2'd2;

    typedef struct packed {
        logic [2:0]       cls;
        logic [1:0]       form;
        logic             low;
        logic [POS_W-1:0] t;
    } ecu_ctrl_t;

    typedef logic [POS_W-1:0] sine_rom_t [0:SINE_TABLE_ENTRIES];

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] ANGLE_DIV = 64'(2 * SINE_TABLE_ENTRIES);
    localparam logic [63:0] TAYLOR_DIV [1:11] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506
    };

    // sin(k*pi/(2N)) in Q16 from a truncated Taylor series in Q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++)
        begin
            x    = (64'(k) * PI_Q30) / ANGLE_DIV;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n < 12; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if ((n & 1) == 1)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0)
            begin
                sum = 64'sd0;
            end
            rom[k] = POS_W'((sum + 64'sd8192) >>> 14);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[sv/ecu_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_prep: input stage
// Clamps t, decodes the curve selector, forms the power argument and the
// sine table index and fraction.
// ----------------------------------------------------------------------------
module ecu_prep (
    input  logic                           clk,
    input  logic                           en,
    input  logic [ecu_pkg::KIND_W-1:0]     kind,
    input  logic [ecu_pkg::POS_W-1:0]      position,
    output ecu_pkg::ecu_ctrl_t             ctrl,
    output logic [ecu_pkg::POS_W-1:0]      x,
    output logic [ecu_pkg::SINE_IDX_W-1:0] sine_idx,
    output logic [ecu_pkg::FRAC_W-1:0]     sine_frac
);
    import ecu_pkg::*;

    logic [POS_W-1:0]        t;
    logic [POS_W-1:0]        m;
    logic [POS_W:0]          dbl;
    logic [POS_W-1:0]        v;
    logic [POS_W-1:0]        arg;
    logic [SINE_SCALE_W-1:0] scaled;
    ecu_ctrl_t               ctrl_next;
    ecu_ctrl_t               ctrl_reg;
    logic [POS_W-1:0]        x_next;
    logic [POS_W-1:0]        x_reg;
    logic [SINE_IDX_W-1:0]   idx_reg;
    logic [FRAC_W-1:0]       frac_reg;

    always_comb
    begin
        t   = (position > ONE_Q16) ? ONE_Q16 : position;
        m   = ONE_Q16 - t;
        dbl = {t, 1'b0};
        ctrl_next.t   = t;
        ctrl_next.low = (t[POS_W-1:FRAC_W-1] == 2'b00);
        v = ctrl_next.low ? dbl[POS_W-1:0] : POS_W'({ONE_Q16, 1'b0} - dbl);

        case (kind)
            KIND_SINE_IN, KIND_SINE_OUT, KIND_SINE_INOUT:    ctrl_next.cls = CLS_SINE;
            KIND_QUAD_IN, KIND_QUAD_OUT, KIND_QUAD_INOUT:    ctrl_next.cls = CLS_QUAD;
            KIND_CUBIC_IN, KIND_CUBIC_OUT, KIND_CUBIC_INOUT: ctrl_next.cls = CLS_CUBIC;
            KIND_BACK_IN, KIND_BACK_OUT, KIND_BACK_INOUT:    ctrl_next.cls = CLS_BACK;
            default:                                         ctrl_next.cls = CLS_LINEAR;
        endcase

        case (kind)
            KIND_SINE_OUT, KIND_QUAD_OUT, KIND_CUBIC_OUT, KIND_BACK_OUT:
                ctrl_next.form = FORM_OUT;
            KIND_SINE_INOUT, KIND_QUAD_INOUT, KIND_CUBIC_INOUT, KIND_BACK_INOUT:
                ctrl_next.form = FORM_INOUT;
            default:
                ctrl_next.form = FORM_IN;
        endcase

        case (ctrl_next.form)
            FORM_OUT:
            begin
                x_next = m;
                arg    = t;
            end
            FORM_INOUT:
            begin
                x_next = v;
                arg    = ONE_Q16 - v;
            end
            default:
            begin
                x_next = t;
                arg    = m;
            end
        endcase

        scaled = SINE_SCALE_W'(arg) * SINE_SCALE_W'(SINE_TABLE_ENTRIES);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg <= ctrl_next;
            x_reg    <= x_next;
            idx_reg  <= scaled[SINE_SCALE_W-1:FRAC_W];
            frac_reg <= scaled[FRAC_W-1:0];
        end
    end

    assign ctrl      = ctrl_reg;
    assign x         = x_reg;
    assign sine_idx  = idx_reg;
    assign sine_frac = frac_reg;

endmodule

[sv/ecu_sine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_sine: quarter-wave sine with linear interpolation
// Table read, slope times fraction, rounded sum; the value is then held
// in step with the polynomial path.
// ----------------------------------------------------------------------------
module ecu_sine (
    input  logic                                clk,
    input  logic [ecu_pkg::NUM_STAGES:1]        en,
    input  logic [ecu_pkg::SINE_IDX_W-1:0]      idx,
    input  logic [ecu_pkg::FRAC_W-1:0]          frac,
    output logic signed [ecu_pkg::OUT_W-1:0]    sine_val
);
    import ecu_pkg::*;

    localparam int DIFF_W = POS_W + 1;
    localparam int MUL_W  = DIFF_W + FRAC_W + 1;

    logic [SINE_IDX_W-1:0]     idx_hi;
    logic [POS_W-1:0]          base_next;
    logic signed [DIFF_W-1:0]  diff_next;
    logic [POS_W-1:0]          base_s2_reg;
    logic signed [DIFF_W-1:0]  diff_s2_reg;
    logic [FRAC_W-1:0]         frac_s2_reg;
    logic signed [MUL_W-1:0]   prod_next;
    logic signed [MUL_W-1:0]   prod_s3_reg;
    logic [POS_W-1:0]          base_s3_reg;
    logic signed [MUL_W-1:0]   rnd;
    logic signed [OUT_W-1:0]   val_next;
    logic signed [OUT_W-1:0]   val_s4_reg;
    logic signed [OUT_W-1:0]   val_s5_reg;
    logic signed [OUT_W-1:0]   val_s6_reg;

    always_comb
    begin
        idx_hi = idx + 1'b1;
        if (idx == SINE_IDX_W'(SINE_TABLE_ENTRIES))
        begin
            base_next = SINE_ROM[idx];
            diff_next = '0;
        end
        else
        begin
            base_next = SINE_ROM[idx];
            diff_next = $signed({1'b0, SINE_ROM[idx_hi]}) - $signed({1'b0, SINE_ROM[idx]});
        end
        prod_next = diff_s2_reg * $signed({1'b0, frac_s2_reg});
        rnd       = (prod_s3_reg + MUL_W'(32768)) >>> FRAC_W;
        val_next  = $signed({1'b0, base_s3_reg}) + OUT_W'(rnd);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            base_s2_reg <= base_next;
            diff_s2_reg <= diff_next;
            frac_s2_reg <= frac;
        end
        if (en[3])
        begin
            prod_s3_reg <= prod_next;
            base_s3_reg <= base_s2_reg;
        end
        if (en[4])
        begin
            val_s4_reg <= val_next;
        end
        if (en[5])
        begin
            val_s5_reg <= val_s4_reg;
        end
        if (en[6])
        begin
            val_s6_reg <= val_s5_reg;
        end
    end

    assign sine_val = val_s6_reg;

endmodule

[sv/ecu_power.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_power: quadratic, cubic and back polynomial path
// Square, cube, rounding to Q16, coefficient products, rounded difference.
// ----------------------------------------------------------------------------
module ecu_power (
    input  logic                             clk,
    input  logic [ecu_pkg::NUM_STAGES:1]     en,
    input  logic [ecu_pkg::POS_W-1:0]        x,
    input  ecu_pkg::ecu_ctrl_t               ctrl_s3,
    input  ecu_pkg::ecu_ctrl_t               ctrl_s4,
    input  ecu_pkg::ecu_ctrl_t               ctrl_s5,
    output logic signed [ecu_pkg::OUT_W-1:0] power_val
);
    import ecu_pkg::*;

    localparam int SQ_EXT_W = X2_W + 1;
    localparam int BD_W     = PROD_W + 1;
    localparam logic signed [BD_W-1:0] HALF_LO = BD_W'(64'sd2147483648);
    localparam logic signed [BD_W-1:0] HALF_HI = BD_W'(64'sd4294967296);

    logic [POS_W-1:0]        x_s2_reg;
    logic [X2_W-1:0]         sq_next;
    logic [X2_W-1:0]         sq_s2_reg;
    logic [X3_W-1:0]         cube_next;
    logic [X3_W-1:0]         cube_s3_reg;
    logic [X2_W-1:0]         sq_s3_reg;
    logic [SQ_EXT_W-1:0]     sq_ext;
    logic                    inout_s3;
    logic [POS_W-1:0]        quad_rnd;
    logic [POS_W-1:0]        cube_rnd;
    logic [POS_W-1:0]        sel_next;
    logic [X2_W-1:0]         x3_next;
    logic [POS_W-1:0]        sel_s4_reg;
    logic [X2_W-1:0]         x3_s4_reg;
    logic [X2_W-1:0]         sq_s4_reg;
    logic                    inout_s4;
    logic [COEF_W-1:0]       coef_a;
    logic [COEF_W-1:0]       coef_b;
    logic [PROD_W-1:0]       pa_next;
    logic [PROD_W-1:0]       pb_next;
    logic [PROD_W-1:0]       pa_s5_reg;
    logic [PROD_W-1:0]       pb_s5_reg;
    logic [POS_W-1:0]        sel_s5_reg;
    logic signed [BD_W-1:0]  diff;
    logic signed [BD_W-1:0]  rnd;
    logic signed [OUT_W-1:0] val_next;
    logic signed [OUT_W-1:0] val_s6_reg;

    always_comb
    begin
        sq_next   = X2_W'(x) * X2_W'(x);
        cube_next = X3_W'(sq_s2_reg) * X3_W'(x_s2_reg);

        inout_s3 = (ctrl_s3.form == FORM_INOUT);
        sq_ext   = {1'b0, sq_s3_reg};
        quad_rnd = inout_s3 ? POS_W'((sq_ext + SQ_EXT_W'(65536)) >> 17)
                            : POS_W'((sq_ext + SQ_EXT_W'(32768)) >> 16);
        cube_rnd = inout_s3 ? POS_W'((cube_s3_reg + X3_W'(64'd4294967296)) >> 33)
                            : POS_W'((cube_s3_reg + X3_W'(64'd2147483648)) >> 32);
        sel_next = (ctrl_s3.cls == CLS_QUAD) ? quad_rnd : cube_rnd;
        x3_next  = X2_W'((cube_s3_reg + X3_W'(32768)) >> 16);

        inout_s4 = (ctrl_s4.form == FORM_INOUT);
        coef_a   = inout_s4 ? D3_Q16 : C3_Q16;
        coef_b   = inout_s4 ? C2_Q16 : C1_Q16;
        pa_next  = PROD_W'(x3_s4_reg) * PROD_W'(coef_a);
        pb_next  = PROD_W'(sq_s4_reg) * PROD_W'(coef_b);

        diff = $signed({1'b0, pa_s5_reg}) - $signed({1'b0, pb_s5_reg});
        rnd  = (ctrl_s5.form == FORM_INOUT) ? ((diff + HALF_HI) >>> 33)
                                             : ((diff + HALF_LO) >>> 32);
        val_next = (ctrl_s5.cls == CLS_BACK) ? OUT_W'(rnd) : $signed({1'b0, sel_s5_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            x_s2_reg  <= x;
            sq_s2_reg <= sq_next;
        end
        if (en[3])
        begin
            cube_s3_reg <= cube_next;
            sq_s3_reg   <= sq_s2_reg;
        end
        if (en[4])
        begin
            sel_s4_reg <= sel_next;
            x3_s4_reg  <= x3_next;
            sq_s4_reg  <= sq_s3_reg;
        end
        if (en[5])
        begin
            pa_s5_reg  <= pa_next;
            pb_s5_reg  <= pb_next;
            sel_s5_reg <= sel_s4_reg;
        end
        if (en[6])
        begin
            val_s6_reg <= val_next;
        end
    end

    assign power_val = val_s6_reg;

endmodule

[sv/ecu_finish.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_finish: output stage
// Applies the in, out or in-out mirror, selects the curve and saturates
// into the output register.
// ----------------------------------------------------------------------------
module ecu_finish (
    input  logic                             clk,
    input  logic                             en,
    input  ecu_pkg::ecu_ctrl_t               ctrl,
    input  logic signed [ecu_pkg::OUT_W-1:0] sine_val,
    input  logic signed [ecu_pkg::OUT_W-1:0] power_val,
    output logic signed [ecu_pkg::OUT_W-1:0] eased_value
);
    import ecu_pkg::*;

    localparam int EXT_W = OUT_W + 1;
    localparam logic signed [EXT_W-1:0] ONE_EXT  = EXT_W'(65536);
    localparam logic signed [EXT_W-1:0] MID_EXT  = EXT_W'(65537);
    localparam logic signed [EXT_W-1:0] LO_EXT   = EXT_W'(SAT_MIN);
    localparam logic signed [EXT_W-1:0] HI_EXT   = EXT_W'(SAT_MAX);

    logic signed [EXT_W-1:0] s_ext;
    logic signed [EXT_W-1:0] p_ext;
    logic                    mirror;
    logic signed [EXT_W-1:0] res;
    logic signed [OUT_W-1:0] eased_next;
    logic signed [OUT_W-1:0] eased_reg;

    always_comb
    begin
        s_ext  = {sine_val[OUT_W-1], sine_val};
        p_ext  = {power_val[OUT_W-1], power_val};
        mirror = (ctrl.form == FORM_OUT) || ((ctrl.form == FORM_INOUT) && !ctrl.low);

        case (ctrl.cls)
            CLS_LINEAR:
                res = $signed({2'b00, ctrl.t});
            CLS_SINE:
            begin
                case (ctrl.form)
                    FORM_IN:    res = ONE_EXT - s_ext;
                    FORM_OUT:   res = s_ext;
                    FORM_INOUT: res = ctrl.low ? ((MID_EXT - s_ext) >>> 1)
                                               : ((MID_EXT + s_ext) >>> 1);
                    default:    res = s_ext;
                endcase
            end
            default:
                res = mirror ? (ONE_EXT - p_ext) : p_ext;
        endcase

        if (res < LO_EXT)
        begin
            eased_next = SAT_MIN;
        end
        else if (res > HI_EXT)
        begin
            eased_next = SAT_MAX;
        end
        else
        begin
            eased_next = res[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eased_reg <= eased_next;
        end
    end

    assign eased_value = eased_reg;

endmodule

[sv/easing_curve_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easing_curve_unit: fixed-point easing curve evaluator
// Linear, sine, quadratic, cubic and back curves in in, out and in-out
// forms; t in Q1.16, result in signed Q16, saturated to -0.125..1.125.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------
//   item     | item_valid / item_stall  | kind[3:0], position[16:0]
//   result   | result_valid / result_stall | eased_value[17:0] signed
//
// One item per cycle unless a stall on result backs the pipeline up.
// The slowest paths are the stage-five coefficient products and the
// stage-six rounded difference of the back polynomial.
// Reset clears the stage valid bits only; no state is kept between items.
// A stall on result holds the output; empty stages still fill, so
// item_stall rises only when all seven stages hold a transfer.
// ----------------------------------------------------------------------------
module easing_curve_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [ecu_pkg::KIND_W-1:0]       kind,
    input  logic [ecu_pkg::POS_W-1:0]        position,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic signed [ecu_pkg::OUT_W-1:0] eased_value
);
    import ecu_pkg::*;

    logic [NUM_STAGES:1]     vld_reg;
    logic [NUM_STAGES:1]     vld_next;
    logic [NUM_STAGES:1]     vld_src;
    logic [NUM_STAGES:1]     en;
    ecu_ctrl_t               ctrl_s1;
    ecu_ctrl_t               ctrl_at [1:NUM_STAGES-1];
    ecu_ctrl_t               ctrl_pipe_reg [2:NUM_STAGES-1];
    logic [POS_W-1:0]        x_s1;
    logic [SINE_IDX_W-1:0]   idx_s1;
    logic [FRAC_W-1:0]       frac_s1;
    logic signed [OUT_W-1:0] sine_val;
    logic signed [OUT_W-1:0] power_val;

    always_comb
    begin
        en[NUM_STAGES] = !vld_reg[NUM_STAGES] || !result_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_src  = {vld_reg[NUM_STAGES-1:1], item_valid};
        vld_next = (en & vld_src) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        ctrl_at[1] = ctrl_s1;
        for (int k = 2; k < NUM_STAGES; k++)
        begin
            ctrl_at[k] = ctrl_pipe_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 2; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                ctrl_pipe_reg[k] <= ctrl_at[k-1];
            end
        end
    end

    ecu_prep u_prep (
        .clk       (clk),
        .en        (en[1]),
        .kind      (kind),
        .position  (position),
        .ctrl      (ctrl_s1),
        .x         (x_s1),
        .sine_idx  (idx_s1),
        .sine_frac (frac_s1)
    );

    ecu_sine u_sine (
        .clk      (clk),
        .en       (en),
        .idx      (idx_s1),
        .frac     (frac_s1),
        .sine_val (sine_val)
    );

    ecu_power u_power (
        .clk       (clk),
        .en        (en),
        .x         (x_s1),
        .ctrl_s3   (ctrl_at[3]),
        .ctrl_s4   (ctrl_at[4]),
        .ctrl_s5   (ctrl_at[5]),
        .power_val (power_val)
    );

    ecu_finish u_finish (
        .clk         (clk),
        .en          (en[NUM_STAGES]),
        .ctrl        (ctrl_at[NUM_STAGES-1]),
        .sine_val    (sine_val),
        .power_val   (power_val),
        .eased_value (eased_value)
    );

    assign item_stall   = !en[1];
    assign result_valid = vld_reg[NUM_STAGES];

endmodule

[sv/ecu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_checker: port-level checks of the easing curve unit
// Backpressure, result range, hold under stall and linear-curve latency.
// ----------------------------------------------------------------------------
module ecu_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_stall,
    input logic [ecu_pkg::KIND_W-1:0]       kind,
    input logic [ecu_pkg::POS_W-1:0]        position,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic signed [ecu_pkg::OUT_W-1:0] eased_value
);
    import ecu_pkg::*;

    logic lin_take;
    logic flowing;

    assign lin_take = rst_n && item_valid && !item_stall && (kind == KIND_LINEAR)
                      && (position <= ONE_Q16);
    assign flowing  = rst_n && !result_stall;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item stall without a stalled result");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((eased_value >= SAT_MIN) && (eased_value <= SAT_MAX)))
        else $error("result outside saturation range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(eased_value)))
        else $error("stalled result changed");

    a_linear_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(lin_take, 7) && $past(flowing, 1) && $past(flowing, 2)
         && $past(flowing, 3) && $past(flowing, 4) && $past(flowing, 5)
         && $past(flowing, 6))
        |-> (result_valid && (eased_value == OUT_W'($past(position, 7)))))
        else $error("linear transfer not returned after seven cycles");

endmodule

bind easing_curve_unit ecu_checker u_ecu_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the easing curve unit
// A queue of curve points feeds a clocked driver. Each accepted transfer is
// evaluated by a local fixed-point curve calculator, with its own quarter-wave
// sine table, and the expected eased value is queued. A clocked monitor checks
// every result transfer against the oldest queued value. Both sides idle at
// random. The receiver holds off once until the pipeline backs up, and the
// sender pauses twice until the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;
    import ecu_pkg::*;

    localparam longint UNIT        = ONE_Q16;
    localparam int     IDLE_PCT    = 7;
    localparam int     HOLD_CYCLES = 60;
    localparam int     HOLD_AT     = 300;
    localparam int     CALM_FIRST  = 1000;
    localparam int     CALM_LAST   = 1300;
    localparam int     RANDOM_ITEMS = 1600;
    localparam int     IDLE_LIMIT  = 1000;
    localparam int     TAIL_CYCLES = 20;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        bit                drain;
    } curve_item_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    item_valid   = 1'b0;
    logic                    item_stall;
    logic [KIND_W-1:0]       kind         = '0;
    logic [POS_W-1:0]        position     = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic signed [OUT_W-1:0] eased_value;

    curve_item_t             pending_items [$];
    logic signed [OUT_W-1:0] expected_eased [$];
    longint                  sine_q16 [0:SINE_TABLE_ENTRIES];

    int items_sent   = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int quiet_cycles = 0;
    bit calm;

    easing_curve_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .position     (position),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .eased_value  (eased_value)
    );

    always #2 clk = ~clk;

    assign calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);

    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sine_at(longint u);
        longint s;
        longint idx;
        longint frac;
        s    = u * SINE_TABLE_ENTRIES;
        idx  = s >>> 16;
        frac = s & 64'hFFFF;
        if (idx >= SINE_TABLE_ENTRIES)
        begin
            return sine_q16[SINE_TABLE_ENTRIES];
        end
        return sine_q16[idx] + round_q((sine_q16[idx + 1] - sine_q16[idx]) * frac, 16);
    endfunction

    function automatic longint back_curve(longint x, longint a, longint b);
        longint x2;
        longint x3;
        x2 = x * x;
        x3 = round_q(x2 * x, 16);
        return a * x3 - b * x2;
    endfunction

    function automatic longint quad_rise(longint x);
        return round_q(x * x, 16);
    endfunction

    function automatic longint cubic_rise(longint x);
        return round_q(x * x * x, 32);
    endfunction

    function automatic longint back_rise(longint x);
        return round_q(back_curve(x, longint'(C3_Q16), longint'(C1_Q16)), 32);
    endfunction

    function automatic logic signed [OUT_W-1:0] eased_point(logic [KIND_W-1:0] k,
                                                           logic [POS_W-1:0] p);
        longint t;
        longint m;
        longint v;
        longint c;
        longint r;
        bit     low;
        t   = (p > ONE_Q16) ? UNIT : longint'(p);
        m   = UNIT - t;
        low = t < (UNIT / 2);
        v   = low ? 2 * t : 2 * UNIT - 2 * t;
        case (k)
            KIND_SINE_IN:   r = UNIT - sine_at(m);
            KIND_SINE_OUT:  r = sine_at(t);
            KIND_SINE_INOUT:
            begin
                c = low ? sine_at(UNIT - v) : -sine_at(UNIT - v);
                r = round_q(UNIT - c, 1);
            end
            KIND_QUAD_IN:    r = quad_rise(t);
            KIND_QUAD_OUT:   r = UNIT - quad_rise(m);
            KIND_QUAD_INOUT: r = low ? round_q(v * v, 17) : UNIT - round_q(v * v, 17);
            KIND_CUBIC_IN:   r = cubic_rise(t);
            KIND_CUBIC_OUT:  r = UNIT - cubic_rise(m);
            KIND_CUBIC_INOUT:
                r = low ? round_q(v * v * v, 33) : UNIT - round_q(v * v * v, 33);
            KIND_BACK_IN:    r = back_rise(t);
            KIND_BACK_OUT:   r = UNIT - back_rise(m);
            KIND_BACK_INOUT:
            begin
                c = round_q(back_curve(v, longint'(D3_Q16), longint'(C2_Q16)), 33);
                r = low ? c : UNIT - c;
            end
            default:         r = t;
        endcase
        if (r < longint'(SAT_MIN))
        begin
            r = longint'(SAT_MIN);
        end
        if (r > longint'(SAT_MAX))
        begin
            r = longint'(SAT_MAX);
        end
        return r[OUT_W-1:0];
    endfunction

    always @(posedge clk)
    begin : drive_items
        curve_item_t head;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                expected_eased.push_back(eased_point(kind, position));
                items_sent <= items_sent + 1;
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() == 0 || (!calm && $urandom_range(99) < IDLE_PCT))
                begin
                    item_valid <= 1'b0;
                end
                else if (pending_items[0].drain && expected_eased.size() != 0)
                begin
                    item_valid <= 1'b0;
                end
                else
                begin
                    head = pending_items.pop_front();
                    item_valid <= 1'b1;
                    kind       <= head.kind;
                    position   <= head.position;
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        logic signed [OUT_W-1:0] want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_eased.size() == 0)
                begin
                    $error("eased_value: expected none, got %0d", eased_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_eased.pop_front();
                    if (eased_value !== want)
                    begin
                        $error("eased_value: expected %0d, got %0d", want, eased_value);
                        fail_count++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (hold_left != 0)
            begin
                result_stall <= 1'b1;
                hold_left    <= hold_left - 1;
            end
            else if (!hold_done && results_seen == HOLD_AT)
            begin
                result_stall <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                hold_done    <= 1'b1;
            end
            else
            begin
                result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        curve_item_t        item;
        int                 edge_pos [0:7];
        int                 extra_kind [0:8];
        int                 extra_pos [0:8];
        int                 sel;
        int                 p;

        // build the quarter-wave sine table in Q16
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++)
        begin
            x    = (64'(k) * PI_Q30) / 64'(2 * SINE_TABLE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n < 12; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            sine_q16[k] = round_q(sum, 14);
        end

        edge_pos   = '{0, 65536, 32768, 32767, 131071, 1, 65535, 65537};
        extra_kind = '{2, 1, 3, 12, 12, 10, 11, 0, 15};
        extra_pos  = '{65536, 0, 32768, 32767, 32768, 65536, 0, 131071, 65536};

        // every curve, then the sine end point, the midpoint split, clamping
        item.drain = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            item.kind     = KIND_W'(k);
            item.position = POS_W'(edge_pos[k % 8]);
            pending_items.push_back(item);
        end
        for (int i = 0; i < 9; i++)
        begin
            item.kind     = KIND_W'(extra_kind[i]);
            item.position = POS_W'(extra_pos[i]);
            pending_items.push_back(item);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(99) < 90)
            begin
                item.kind = KIND_W'($urandom_range(12));
            end
            else
            begin
                item.kind = KIND_W'($urandom_range(15, 13));
            end
            sel = $urandom_range(99);
            if (sel < 75)
            begin
                p = $urandom_range(65536);
            end
            else if (sel < 87)
            begin
                p = $urandom_range(131071, 65537);
            end
            else
            begin
                p = $urandom_range(2) * 32768 + $urandom_range(6) - 3;
                if (p < 0)
                begin
                    p = 0;
                end
            end
            item.position = POS_W'(p);
            item.drain    = (i == 400) || (i == 1200);
            pending_items.push_back(item);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_valid || expected_eased.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_eased.size() != 0)
        begin
            $error("eased_value: %0d results never arrived", expected_eased.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/ecu_pkg.sv
sv/ecu_prep.sv
sv/ecu_sine.sv
sv/ecu_power.sv
sv/ecu_finish.sv
sv/easing_curve_unit.sv
sv/ecu_checker.sv
tb/sv/tb_top.sv
